[sv/antialiased_line_rasterizer_assert.svh]
// assertion macros for the line rasteriser
// no dependencies; taken in by the top level
`ifndef ANTIALIASED_LINE_RASTERIZER_ASSERT_SVH
`define ANTIALIASED_LINE_RASTERIZER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ALR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ALR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/alr_pkg.sv]
// shared types, codes and helpers of the line rasteriser
// no dependencies
package alr_pkg;

    // opcodes of the input word
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // full coverage weight
    localparam logic [8:0] WEIGHT_FULL = 9'd256;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT0,
        ST_OUT1
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_start;
        logic start_div;
        logic do_step;
        logic sel_second;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic line_active;
        logic need_div;
        logic has_second;
        logic div_done;
    } status_t;

    // channel scaled by coverage weight, (c*w)>>8
    function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [8:0] w);
        logic [16:0] prod;
        prod = {9'd0, c} * {8'd0, w};
        return prod[15:8];
    endfunction

endpackage

[sv/antialiased_line_rasterizer.sv]
// top level of the anti-aliased line rasteriser
// depends on alr_pkg, alr_ctrl, alr_datapath and the assertion header
//
//   channel   dir  handshake            word
//   s_*       in   s_valid / s_ready    op, endpoints, rgba colour
//   m_*       out  m_valid / m_ready    one pixel: x, y, scaled rgba, last
//
// a step word is taken, then each of its one or two pixels
// is held in the output register until the sink takes it
// a start word of a sloped line runs the restoring slope divider
// before the next word is taken; an axis-aligned start needs none
// reset is synchronous, active low, and leaves no line in progress
// input is refused while pixels wait on the output or the divider runs
module antialiased_line_rasterizer #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic [COORD_BITS-1:0] s_start_x,
    input  logic [COORD_BITS-1:0] s_start_y,
    input  logic [COORD_BITS-1:0] s_end_x,
    input  logic [COORD_BITS-1:0] s_end_y,
    input  logic [7:0]            s_red,
    input  logic [7:0]            s_green,
    input  logic [7:0]            s_blue,
    input  logic [7:0]            s_alpha,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_pixel_x,
    output logic [COORD_BITS-1:0] m_pixel_y,
    output logic [7:0]            m_out_red,
    output logic [7:0]            m_out_green,
    output logic [7:0]            m_out_blue,
    output logic [7:0]            m_out_alpha,
    output logic                  m_last_pixel
);

    `include "antialiased_line_rasterizer_assert.svh"

    alr_pkg::cmd_t    cmd;
    alr_pkg::status_t status;

    alr_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_op   (s_op),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .status (status),
        .cmd    (cmd)
    );

    alr_datapath #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .start_x   (s_start_x),
        .start_y   (s_start_y),
        .end_x     (s_end_x),
        .end_y     (s_end_y),
        .red       (s_red),
        .green     (s_green),
        .blue      (s_blue),
        .alpha     (s_alpha),
        .pixel_x   (m_pixel_x),
        .pixel_y   (m_pixel_y),
        .out_red   (m_out_red),
        .out_green (m_out_green),
        .out_blue  (m_out_blue),
        .out_alpha (m_out_alpha),
        .last_pixel(m_last_pixel)
    );

    // checks on the controller and datapath working together
    `ALR_ASSERT_IMP(a_one_at_a_time, aclk, aresetn, m_valid, !s_ready, "input taken while pixel pending")
    `ALR_ASSERT_NXT(a_step_gives_pixel, aclk, aresetn, s_valid && s_ready && (s_op == alr_pkg::OP_STEP) && status.line_active, m_valid, "step with a line gave no pixel")
    `ALR_ASSERT_IMP(a_last_ends_line, aclk, aresetn, m_valid && m_last_pixel, !status.line_active, "last pixel while line still active")

endmodule

[sv/alr_divider.sv]
// restoring divider for the minor-axis slope, one quotient bit a cycle
// depends on nothing but its parameters
module alr_divider #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] dmin,
    input  logic [COORD_BITS-1:0] dmaj,
    output logic                  done,
    output logic [FRAC_BITS:0]    quotient
);

    localparam int ITER  = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(ITER + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [COORD_BITS:0]   rem_reg, rem_next;
    logic [COORD_BITS-1:0] div_reg, div_next;
    logic [FRAC_BITS:0]    quo_reg, quo_next;
    logic [COORD_BITS:0]   diff;
    logic                  ge;
    logic [COORD_BITS:0]   kept;

    // one compare and subtract
    always_comb begin
        ge   = rem_reg >= {1'b0, div_reg};
        diff = rem_reg - {1'b0, div_reg};
        kept = ge ? diff : rem_reg;
    end

    // iteration control
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ITER);
            rem_next  = {1'b0, dmin};
            div_next  = dmaj;
        end else if (busy_reg) begin
            quo_next = {quo_reg[FRAC_BITS-1:0], ge};
            rem_next = {kept[COORD_BITS-1:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[sv/alr_ctrl.sv]
// controller state machine of the line rasteriser
// depends on alr_pkg
module alr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_op,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  alr_pkg::status_t  status,
    output alr_pkg::cmd_t     cmd
);

    alr_pkg::state_t state_reg, state_next;
    logic            in_take;

    assign in_take = (state_reg == alr_pkg::ST_IDLE) && s_valid;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            alr_pkg::ST_IDLE: begin
                if (in_take) begin
                    if (s_op == alr_pkg::OP_START) begin
                        if (status.need_div) state_next = alr_pkg::ST_DIV;
                    end else if (status.line_active) begin
                        state_next = alr_pkg::ST_OUT0;
                    end
                end
            end
            alr_pkg::ST_DIV: begin
                if (status.div_done) state_next = alr_pkg::ST_IDLE;
            end
            alr_pkg::ST_OUT0: begin
                if (m_ready) begin
                    state_next = status.has_second ? alr_pkg::ST_OUT1 : alr_pkg::ST_IDLE;
                end
            end
            alr_pkg::ST_OUT1: begin
                if (m_ready) state_next = alr_pkg::ST_IDLE;
            end
            default: state_next = alr_pkg::ST_IDLE;
        endcase
    end

    // outputs and commands
    always_comb begin
        s_ready        = state_reg == alr_pkg::ST_IDLE;
        m_valid        = (state_reg == alr_pkg::ST_OUT0) || (state_reg == alr_pkg::ST_OUT1);
        cmd.load_start = in_take && (s_op == alr_pkg::OP_START);
        cmd.start_div  = in_take && (s_op == alr_pkg::OP_START) && status.need_div;
        cmd.do_step    = in_take && (s_op == alr_pkg::OP_STEP) && status.line_active;
        cmd.sel_second = state_reg == alr_pkg::ST_OUT1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= alr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/alr_datapath.sv]
// line state, set-up, stepping and pixel words of the rasteriser
// depends on alr_pkg and alr_divider
module alr_datapath #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  alr_pkg::cmd_t         cmd,
    output alr_pkg::status_t      status,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic [7:0]            alpha,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic [7:0]            out_red,
    output logic [7:0]            out_green,
    output logic [7:0]            out_blue,
    output logic [7:0]            out_alpha,
    output logic                  last_pixel
);

    localparam int MINOR_W = COORD_BITS + FRAC_BITS;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [7:0]            r;
        logic [7:0]            g;
        logic [7:0]            b;
        logic [7:0]            a;
        logic                  last;
    } pix_t;

    // line state
    logic [COORD_BITS-1:0] pos_reg, pos_next;
    logic [COORD_BITS-1:0] end_reg, end_next;
    logic [MINOR_W-1:0]    minor_reg, minor_next;
    logic [FRAC_BITS:0]    slope_reg, slope_next;
    logic                  maj_x_reg, maj_x_next;
    logic                  maj_neg_reg, maj_neg_next;
    logic                  min_neg_reg, min_neg_next;
    logic                  axis_reg, axis_next;
    logic [31:0]           color_reg, color_next;
    logic                  active_reg, active_next;
    logic                  has2_reg, has2_next;
    pix_t                  word0_reg, word0_next;
    pix_t                  word1_reg, word1_next;

    // set-up terms
    logic [COORD_BITS-1:0] dx, dy, dmaj, dmin;
    logic                  axis_in, s_maj_x;
    logic                  div_done;
    logic [FRAC_BITS:0]    quotient;

    // step terms
    logic [COORD_BITS-1:0] fl, fl1, nxt;
    logic [8:0]            wt;
    logic                  wu_last, second, ax_last;

    alr_divider #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start_div),
        .dmin    (dmin),
        .dmaj    (dmaj),
        .done    (div_done),
        .quotient(quotient)
    );

    // pixel word from major and minor coordinates
    function automatic pix_t make_pix(
        input logic                  maj_x,
        input logic [COORD_BITS-1:0] mj,
        input logic [COORD_BITS-1:0] mn,
        input logic [31:0]           col,
        input logic [8:0]            w,
        input logic                  last
    );
        pix_t p;
        p.x    = maj_x ? mj : mn;
        p.y    = maj_x ? mn : mj;
        p.r    = alr_pkg::scale_chan(col[31:24], w);
        p.g    = alr_pkg::scale_chan(col[23:16], w);
        p.b    = alr_pkg::scale_chan(col[15:8], w);
        p.a    = alr_pkg::scale_chan(col[7:0], w);
        p.last = last;
        return p;
    endfunction

    // endpoint differences and major axis choice
    always_comb begin
        dx      = (start_x > end_x) ? (start_x - end_x) : (end_x - start_x);
        dy      = (start_y > end_y) ? (start_y - end_y) : (end_y - start_y);
        axis_in = (start_x == end_x) || (start_y == end_y);
        s_maj_x = axis_in ? !(dx < dy) : (dx > dy);
        dmaj    = s_maj_x ? dx : dy;
        dmin    = s_maj_x ? dy : dx;
    end

    // current step
    always_comb begin
        fl      = minor_reg[MINOR_W-1:FRAC_BITS];
        fl1     = fl + COORD_BITS'(1);
        wt      = {1'b0, minor_reg[FRAC_BITS-1:FRAC_BITS-8]};
        nxt     = maj_neg_reg ? (pos_reg - COORD_BITS'(1)) : (pos_reg + COORD_BITS'(1));
        wu_last = nxt == end_reg;
        second  = ~&fl;
        ax_last = pos_reg == end_reg;
    end

    // state update
    always_comb begin
        pos_next     = pos_reg;
        end_next     = end_reg;
        minor_next   = minor_reg;
        slope_next   = slope_reg;
        maj_x_next   = maj_x_reg;
        maj_neg_next = maj_neg_reg;
        min_neg_next = min_neg_reg;
        axis_next    = axis_reg;
        color_next   = color_reg;
        active_next  = active_reg;
        has2_next    = has2_reg;
        word0_next   = word0_reg;
        word1_next   = word1_reg;
        if (cmd.load_start) begin
            color_next  = {red, green, blue, alpha};
            active_next = 1'b1;
            axis_next   = axis_in;
            maj_x_next  = s_maj_x;
            slope_next  = '0;
            if (axis_in) begin
                maj_neg_next = 1'b0;
                min_neg_next = 1'b0;
                if (s_maj_x) begin
                    pos_next   = (start_x < end_x) ? start_x : end_x;
                    end_next   = (start_x < end_x) ? end_x : start_x;
                    minor_next = {start_y, {FRAC_BITS{1'b0}}};
                end else begin
                    pos_next   = (start_y < end_y) ? start_y : end_y;
                    end_next   = (start_y < end_y) ? end_y : start_y;
                    minor_next = {start_x, {FRAC_BITS{1'b0}}};
                end
            end else if (s_maj_x) begin
                pos_next     = start_x;
                end_next     = end_x;
                minor_next   = {start_y, {FRAC_BITS{1'b0}}};
                maj_neg_next = end_x < start_x;
                min_neg_next = end_y < start_y;
            end else begin
                pos_next     = start_y;
                end_next     = end_y;
                minor_next   = {start_x, {FRAC_BITS{1'b0}}};
                maj_neg_next = end_y < start_y;
                min_neg_next = end_x < start_x;
            end
        end else if (cmd.do_step) begin
            if (axis_reg) begin
                word0_next  = make_pix(maj_x_reg, pos_reg, fl, color_reg,
                                       alr_pkg::WEIGHT_FULL, ax_last);
                has2_next   = 1'b0;
                active_next = !ax_last;
                if (!ax_last) pos_next = pos_reg + COORD_BITS'(1);
            end else begin
                word0_next  = make_pix(maj_x_reg, pos_reg, fl, color_reg,
                                       alr_pkg::WEIGHT_FULL - wt, wu_last && !second);
                word1_next  = make_pix(maj_x_reg, pos_reg, fl1, color_reg, wt, wu_last);
                has2_next   = second;
                active_next = !wu_last;
                pos_next    = nxt;
                if (min_neg_reg) begin
                    minor_next = minor_reg - {{(COORD_BITS - 1){1'b0}}, slope_reg};
                end else begin
                    minor_next = minor_reg + {{(COORD_BITS - 1){1'b0}}, slope_reg};
                end
            end
        end
        // slope lands once the divider finishes
        if (div_done) slope_next = quotient;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            has2_reg   <= 1'b0;
        end else begin
            active_reg <= active_next;
            has2_reg   <= has2_next;
        end
        pos_reg     <= pos_next;
        end_reg     <= end_next;
        minor_reg   <= minor_next;
        slope_reg   <= slope_next;
        maj_x_reg   <= maj_x_next;
        maj_neg_reg <= maj_neg_next;
        min_neg_reg <= min_neg_next;
        axis_reg    <= axis_next;
        color_reg   <= color_next;
        word0_reg   <= word0_next;
        word1_reg   <= word1_next;
    end

    // status back to the controller
    always_comb begin
        status.line_active = active_reg;
        status.need_div    = !axis_in;
        status.has_second  = has2_reg;
        status.div_done    = div_done;
    end

    // output word select
    always_comb begin
        pix_t sel;
        sel        = cmd.sel_second ? word1_reg : word0_reg;
        pixel_x    = sel.x;
        pixel_y    = sel.y;
        out_red    = sel.r;
        out_green  = sel.g;
        out_blue   = sel.b;
        out_alpha  = sel.a;
        last_pixel = sel.last;
    end

endmodule

[tb/testbench.sv]
// self-checking testbench for the anti-aliased line rasteriser: line words in, pixel words out
// depends on alr_pkg and antialiased_line_rasterizer; carries its own pixel predictor
`timescale 1ns / 100ps

module testbench;

    localparam int CW = 12;
    localparam int FW = 16;
    localparam int QUIET_LIMIT = 3000;
    localparam int LINE_WORDS = 1150;

    // one input word as queued for the driver
    typedef struct {
        logic          op;
        logic [CW-1:0] sx, sy, ex, ey;
        logic [31:0]   rgba;
        bit            drain_first;
    } line_word_t;

    // one expected pixel word
    typedef struct {
        logic [CW-1:0] x, y;
        logic [7:0]    r, g, b, a;
        logic          last;
    } pixel_t;

    typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic          s_op = alr_pkg::OP_START;
    logic [CW-1:0] s_start_x = '0;
    logic [CW-1:0] s_start_y = '0;
    logic [CW-1:0] s_end_x = '0;
    logic [CW-1:0] s_end_y = '0;
    logic [7:0]    s_red = '0;
    logic [7:0]    s_green = '0;
    logic [7:0]    s_blue = '0;
    logic [7:0]    s_alpha = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [CW-1:0] m_pixel_x, m_pixel_y;
    logic [7:0]    m_out_red, m_out_green, m_out_blue, m_out_alpha;
    logic          m_last_pixel;

    line_word_t pending_words[$];
    pixel_t     pixel_q[$];
    int         mismatch_count = 0;

    // predictor copy of the line state
    logic [CW-1:0]    trace_pos = '0;
    logic [CW-1:0]    trace_end = '0;
    logic [CW+FW-1:0] trace_minor = '0;
    logic [FW:0]      trace_slope = '0;
    logic             trace_major_x = 1'b0;
    logic             trace_major_neg = 1'b0;
    logic             trace_minor_neg = 1'b0;
    logic             trace_aligned = 1'b0;
    logic             trace_active = 1'b0;
    logic [31:0]      trace_colour = '0;

    antialiased_line_rasterizer dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .s_alpha      (s_alpha),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_x    (m_pixel_x),
        .m_pixel_y    (m_pixel_y),
        .m_out_red    (m_out_red),
        .m_out_green  (m_out_green),
        .m_out_blue   (m_out_blue),
        .m_out_alpha  (m_out_alpha),
        .m_last_pixel (m_last_pixel)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40) begin
            $display("%0t mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got, input int unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    // channel times coverage weight, keeping bits 15:8 of the product
    function automatic logic [7:0] weigh(input logic [7:0] c, input logic [8:0] wt);
        logic [16:0] prod;
        prod = {9'd0, c} * {8'd0, wt};
        return prod[15:8];
    endfunction

    function automatic pixel_t shade_pixel(input logic [CW-1:0] mj, input logic [CW-1:0] mn,
                                           input logic [8:0] wt, input logic fin);
        pixel_t p;
        p.x    = trace_major_x ? mj : mn;
        p.y    = trace_major_x ? mn : mj;
        p.r    = weigh(trace_colour[31:24], wt);
        p.g    = weigh(trace_colour[23:16], wt);
        p.b    = weigh(trace_colour[15:8], wt);
        p.a    = weigh(trace_colour[7:0], wt);
        p.last = fin;
        return p;
    endfunction

    // update the line state for one accepted word and queue the pixels it yields
    task automatic rasterise_word(input line_word_t w);
        logic [CW-1:0]    dx, dy, dmaj, dmin, fl, nxt;
        logic [8:0]       wt;
        logic             fin, has_upper;
        logic [CW+FW-1:0] quo;
        if (w.op == alr_pkg::OP_START) begin
            dx = (w.sx > w.ex) ? w.sx - w.ex : w.ex - w.sx;
            dy = (w.sy > w.ey) ? w.sy - w.ey : w.ey - w.sy;
            trace_colour = w.rgba;
            trace_active = 1'b1;
            if (w.sx == w.ex || w.sy == w.ey) begin
                // straight line: walk upwards from the lower end, full colour
                trace_aligned   = 1'b1;
                trace_major_x   = !(dx < dy);
                trace_major_neg = 1'b0;
                trace_minor_neg = 1'b0;
                trace_slope     = '0;
                if (trace_major_x) begin
                    trace_pos   = (w.sx < w.ex) ? w.sx : w.ex;
                    trace_end   = (w.sx < w.ex) ? w.ex : w.sx;
                    trace_minor = {w.sy, {FW{1'b0}}};
                end else begin
                    trace_pos   = (w.sy < w.ey) ? w.sy : w.ey;
                    trace_end   = (w.sy < w.ey) ? w.ey : w.sy;
                    trace_minor = {w.sx, {FW{1'b0}}};
                end
            end else begin
                trace_aligned = 1'b0;
                trace_major_x = dx > dy;
                if (trace_major_x) begin
                    trace_pos       = w.sx;
                    trace_end       = w.ex;
                    trace_minor     = {w.sy, {FW{1'b0}}};
                    trace_major_neg = w.ex < w.sx;
                    trace_minor_neg = w.ey < w.sy;
                    dmaj = dx;
                    dmin = dy;
                end else begin
                    trace_pos       = w.sy;
                    trace_end       = w.ey;
                    trace_minor     = {w.sx, {FW{1'b0}}};
                    trace_major_neg = w.ey < w.sy;
                    trace_minor_neg = w.ex < w.sx;
                    dmaj = dy;
                    dmin = dx;
                end
                quo         = {dmin, {FW{1'b0}}} / {{FW{1'b0}}, dmaj};
                trace_slope = quo[FW:0];
            end
        end else if (trace_active) begin
            if (trace_aligned) begin
                fin = trace_pos == trace_end;
                pixel_q.push_back(shade_pixel(trace_pos, trace_minor[CW+FW-1:FW], 9'd256, fin));
                if (fin) begin
                    trace_active = 1'b0;
                end else begin
                    trace_pos = trace_pos + CW'(1);
                end
            end else begin
                // floor pixel, then the one above unless it is off the raster
                fl        = trace_minor[CW+FW-1:FW];
                wt        = {1'b0, trace_minor[FW-1:FW-8]};
                nxt       = trace_major_neg ? trace_pos - CW'(1) : trace_pos + CW'(1);
                fin       = nxt == trace_end;
                has_upper = fl != {CW{1'b1}};
                pixel_q.push_back(shade_pixel(trace_pos, fl, 9'd256 - wt, fin && !has_upper));
                if (has_upper) begin
                    pixel_q.push_back(shade_pixel(trace_pos, fl + CW'(1), wt, fin));
                end
                if (trace_minor_neg) begin
                    trace_minor = trace_minor - {{(CW-1){1'b0}}, trace_slope};
                end else begin
                    trace_minor = trace_minor + {{(CW-1){1'b0}}, trace_slope};
                end
                trace_pos = nxt;
                if (fin) begin
                    trace_active = 1'b0;
                end
            end
        end
    endtask

    // stimulus builders
    task automatic queue_start(input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                               input logic [CW-1:0] ex, input logic [CW-1:0] ey,
                               input logic [31:0] rgba, input bit drain);
        line_word_t w;
        w.op          = alr_pkg::OP_START;
        w.sx          = sx;
        w.sy          = sy;
        w.ex          = ex;
        w.ey          = ey;
        w.rgba        = rgba;
        w.drain_first = drain;
        pending_words.push_back(w);
    endtask

    // step words carry random junk in the fields they do not use
    task automatic queue_steps(input int n);
        line_word_t w;
        for (int i = 0; i < n; i++) begin
            w.op          = alr_pkg::OP_STEP;
            w.sx          = CW'($urandom);
            w.sy          = CW'($urandom);
            w.ex          = CW'($urandom);
            w.ey          = CW'($urandom);
            w.rgba        = $urandom;
            w.drain_first = 1'b0;
            pending_words.push_back(w);
        end
    endtask

    function automatic int line_length(input int sx, input int sy, input int ex, input int ey);
        int dx, dy;
        dx = sx > ex ? sx - ex : ex - sx;
        dy = sy > ey ? sy - ey : ey - sy;
        if (sx == ex || sy == ey) begin
            return (dx > dy ? dx : dy) + 1;
        end
        return dx > dy ? dx : dy;
    endfunction

    // mostly anywhere, sometimes hugging either border
    function automatic int edge_coord();
        if ($urandom_range(0, 3) != 0) begin
            return $urandom_range(0, 4095);
        end
        return $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(4092, 4095);
    endfunction

    // offset a coordinate by d in a random direction, staying on the raster
    function automatic int place(input int c, input int d);
        bit up;
        up = $urandom_range(0, 1);
        if (up && c + d > 4095) begin
            up = 1'b0;
        end else if (!up && c < d) begin
            up = 1'b1;
        end
        return up ? c + d : c - d;
    endfunction

    // driver: bursts of words with random gaps, optional drain before a word
    int burst_left = 1;
    int gap_left = 0;
    line_word_t cur_word;

    always @(posedge aclk) begin : drive_words
        bit take;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            take = s_valid && s_ready;
            if (take) begin
                rasterise_word(cur_word);
                burst_left--;
                if (burst_left <= 0) begin
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
                end
            end
            if (!s_valid || take) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_words.size() != 0 &&
                             !(pending_words[0].drain_first && pixel_q.size() != 0)) begin
                    cur_word = pending_words.pop_front();
                    s_valid   <= 1'b1;
                    s_op      <= cur_word.op;
                    s_start_x <= cur_word.sx;
                    s_start_y <= cur_word.sy;
                    s_end_x   <= cur_word.ex;
                    s_end_y   <= cur_word.ey;
                    s_red     <= cur_word.rgba[31:24];
                    s_green   <= cur_word.rgba[23:16];
                    s_blue    <= cur_word.rgba[15:8];
                    s_alpha   <= cur_word.rgba[7:0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each pixel word, and stall the output at random or on a changing pattern
    sink_mode_t  sink_mode = SINK_OPEN;
    int          sink_mode_left = 0;
    logic [31:0] sink_pattern = 32'h1;

    always @(posedge aclk) begin : watch_pixels
        pixel_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pixel_q.size() == 0) begin
                    report_mismatch($sformatf("pixel (%0d,%0d) with none pending",
                                              m_pixel_x, m_pixel_y));
                end else begin
                    want = pixel_q.pop_front();
                    check_field("pixel_x", 32'(m_pixel_x), 32'(want.x));
                    check_field("pixel_y", 32'(m_pixel_y), 32'(want.y));
                    check_field("out_red", 32'(m_out_red), 32'(want.r));
                    check_field("out_green", 32'(m_out_green), 32'(want.g));
                    check_field("out_blue", 32'(m_out_blue), 32'(want.b));
                    check_field("out_alpha", 32'(m_out_alpha), 32'(want.a));
                    check_field("last_pixel", 32'(m_last_pixel), 32'(want.last));
                end
            end
            if (sink_mode_left == 0) begin
                sink_mode      = sink_mode_t'($urandom_range(0, 2));
                sink_mode_left = $urandom_range(16, 200);
                sink_pattern   = $urandom | 32'h1;
            end else begin
                sink_mode_left--;
            end
            case (sink_mode)
                SINK_OPEN: begin
                    m_ready <= 1'b1;
                end
                SINK_RANDOM: begin
                    m_ready <= $urandom_range(0, 3) != 0;
                end
                default: begin
                    m_ready <= sink_pattern[0];
                    sink_pattern = {sink_pattern[0], sink_pattern[31:1]};
                end
            endcase
        end
    end

    // watchdog on cycles with no expected word moving on either side
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) ||
            (m_valid && m_ready && pixel_q.size() != 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus, reset and end of run
    initial begin
        int line_words, sz, shape, tail, dmaj, dmin, dx, dy, sx, sy, ex, ey, n, full;
        // step with no line in progress gives nothing
        queue_steps(1);
        // horizontal line given right to left comes out ascending; extra step ignored
        queue_start(12'd5, 12'd7, 12'd2, 12'd7, 32'hFF00_8001, 1'b0);
        queue_steps(5);
        // vertical line on the last column
        queue_start(12'd4095, 12'd12, 12'd4095, 12'd10, 32'hFFFF_FFFF, 1'b0);
        queue_steps(3);
        // single point at the origin, then one ignored step
        queue_start(12'd0, 12'd0, 12'd0, 12'd0, 32'h7F80_01FE, 1'b0);
        queue_steps(2);
        // shallow line from the origin; first upper neighbour has zero weight
        queue_start(12'd0, 12'd0, 12'd3, 12'd1, 32'hFFFF_FFFF, 1'b0);
        queue_steps(3);
        // diagonal tie takes y as major; upper neighbour is off the raster
        queue_start(12'd4095, 12'd4095, 12'd4094, 12'd4094, 32'hFF00_FF00, 1'b1);
        queue_steps(1);
        // a new start abandons the line in progress
        queue_start(12'd100, 12'd200, 12'd90, 12'd230, 32'h0102_0408, 1'b0);
        queue_steps(1);
        queue_start(12'd4095, 12'd0, 12'd4090, 12'd2, 32'h80FF_40C0, 1'b0);
        queue_steps(2);

        // random lines, mostly short and drawn to the end
        line_words = 0;
        while (line_words < LINE_WORDS) begin
            if ($urandom_range(0, 99) < 8) begin
                n = $urandom_range(1, 3);
                queue_steps(n);
                line_words += n;
            end else begin
                sz    = $urandom_range(0, 99);
                dmaj  = (sz < 70) ? $urandom_range(0, 8) :
                        (sz < 95) ? $urandom_range(9, 40) : $urandom_range(41, 200);
                shape = $urandom_range(0, 9);
                dmin  = (shape < 2) ? 0 : (shape == 2) ? dmaj : $urandom_range(0, dmaj);
                if ($urandom_range(0, 1)) begin
                    dx = dmaj;
                    dy = dmin;
                end else begin
                    dx = dmin;
                    dy = dmaj;
                end
                sx   = edge_coord();
                sy   = edge_coord();
                ex   = place(sx, dx);
                ey   = place(sy, dy);
                full = line_length(sx, sy, ex, ey);
                tail = $urandom_range(0, 9);
                n    = full;
                if (tail < 2) begin
                    n = $urandom_range(0, full - 1);
                end else if (tail < 4) begin
                    n = full + $urandom_range(1, 3);
                end
                queue_start(CW'(sx), CW'(sy), CW'(ex), CW'(ey), $urandom,
                            $urandom_range(0, 14) == 0);
                queue_steps(n);
                line_words += 1 + n;
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || s_valid) @(posedge aclk);
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
